// ----- hw/rtl/explosion_impulse_unit_macros.svh -----
// assertion helpers for the explosion impulse unit
`ifndef EXPLOSION_IMPULSE_UNIT_MACROS_SVH
`define EXPLOSION_IMPULSE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on the rising clock edge
`define EIU_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("explosion impulse unit check failed");

// next-cycle implication, sampled on the rising clock edge
`define EIU_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("explosion impulse unit check failed");

`else

`define EIU_ASSERT_NOW(name, cond, prop)
`define EIU_ASSERT_NEXT(name, cond, prop)

`endif

`endif

// ----- hw/rtl/eiu_pkg.sv -----
`timescale 1ns / 1ps

package eiu_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int ONE_INT   = 1 << FRAC_BITS;
    localparam int TENTH_INT = (ONE_INT + 5) / 10;
    // signed width that holds -1.0 .. +1.0
    localparam int QW        = FRAC_BITS + 2;

    typedef enum logic [1:0] {
        ACT_APPLY = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_ARM   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_STRENGTH = 3'd4,
        CFG_BIAS     = 3'd5,
        CFG_DURATION = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFS,
        S_RANGE,
        S_MUL,
        S_MULW,
        S_SQRT,
        S_BIAS,
        S_DVLD,
        S_DIV,
        S_FALL
    } t_state;

    // operations on the shared multiplier
    typedef enum logic [3:0] {
        M_SQD0, M_SQD1, M_SQD2,
        M_SQV0, M_SQV1, M_SQV2,
        M_FF, M_MAG,
        M_IMP0, M_IMP1, M_IMP2,
        M_TQ0A, M_TQ0B, M_TQ1B
    } t_mop;

    // jobs of the shared divider
    typedef enum logic [1:0] {
        DK_OFFS,
        DK_VEC,
        DK_FALL
    } t_dkind;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               is_dynamic;
        logic [30:0]        delta_time;
    } t_in_word;

    typedef struct packed {
        logic               applied;
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
        logic signed [31:0] impulse_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_z;
        logic               expired;
    } t_out_word;

    // clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < 34'sh380000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        logic [33:0] r;
        r = v[33] ? 34'(-v) : 34'(v);
        return r;
    endfunction

endpackage

// ----- hw/rtl/explosion_impulse_unit.sv -----
`timescale 1ns / 1ps
`include "explosion_impulse_unit_macros.svh"

// channel   direction  handshake                     payload
// command   in         start high while busy low     i_in  (t_in_word)
// result    out        o_out_valid one-cycle strobe  o_out (t_out_word)
// config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// tick, arm and unknown commands: result strobe in the cycle after start, busy stays low
// apply: a miss on the quick checks answers from the offset or range state; a full hit
//   runs two 32-step square roots and seven 17-step divisions on the
//   one shared divider plus fourteen passes through the shared multiplier
// reset is synchronous and active low; config registers and remaining time take
//   their reset values, the sequencer returns to idle
// the result strobe cannot be held off; config ready is always high
module explosion_impulse_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  eiu_pkg::t_in_word   i_in,
    output logic                busy,
    output logic                o_out_valid,
    output eiu_pkg::t_out_word  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import eiu_pkg::*;

    localparam logic signed [33:0] ONE_Q   = 34'(ONE_INT);
    localparam logic signed [33:0] TENTH_Q = 34'(TENTH_INT);

    // control and config registers
    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_time_left, n_time_left;
    logic signed [31:0] r_center [3];
    logic [30:0]        r_radius;
    logic signed [31:0] r_strength;
    logic signed [31:0] r_bias;
    logic [30:0]        r_duration;

    // datapath registers
    t_out_word          r_out, n_out;
    logic signed [31:0] r_pos [3], n_pos [3];
    logic               r_dyn, n_dyn;
    logic signed [32:0] r_d [3], n_d [3];
    logic signed [33:0] r_v [3], n_v [3];
    logic signed [QW-1:0] r_n [3], n_n [3];
    logic [63:0]        r_acc, n_acc;
    logic signed [67:0] r_prod;
    t_mop               r_mop, n_mop;
    logic [63:0]        r_sq_n, n_sq_n;
    logic [63:0]        r_sq_res, n_sq_res;
    logic               r_sq_len, n_sq_len;
    logic [4:0]         r_cnt, n_cnt;
    logic [33:0]        r_dv_rem, n_dv_rem;
    logic [31:0]        r_dv_den, n_dv_den;
    logic [FRAC_BITS:0] r_dv_q, n_dv_q;
    logic               r_dv_neg, n_dv_neg;
    t_dkind             r_dv_kind, n_dv_kind;
    logic [1:0]         r_k, n_k;
    logic [31:0]        r_dist, n_dist;
    logic [31:0]        r_len, n_len;
    logic signed [QW-1:0] r_f, n_f;
    logic signed [QW-1:0] r_f2, n_f2;
    logic signed [33:0] r_mag, n_mag;
    logic signed [33:0] r_imp [3], n_imp [3];
    logic signed [33:0] r_t, n_t;
    logic signed [33:0] r_tq0, n_tq0;

    // shared multiplier operands
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_sh;
    logic signed [33:0] psh;

    // square root step
    logic [63:0] sq_bit, sq_t, sq_n_next, sq_res_next;
    logic        sq_ge;

    // divider step
    logic [34:0]          dv_diff;
    logic                 dv_bit;
    logic [33:0]          dv_keep;
    logic [FRAC_BITS:0]   dv_q_next;
    logic signed [QW-1:0] dv_res;

    logic signed [33:0] tick_val;
    logic [31:0]        root;
    t_out_word          miss_word;

    assign busy        = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_mop)
            M_SQD0: begin mul_a = 34'(mag34(34'(r_d[0]))); mul_b = mul_a; end
            M_SQD1: begin mul_a = 34'(mag34(34'(r_d[1]))); mul_b = mul_a; end
            M_SQD2: begin mul_a = 34'(mag34(34'(r_d[2]))); mul_b = mul_a; end
            M_SQV0: begin mul_a = 34'(mag34(r_v[0])); mul_b = mul_a; end
            M_SQV1: begin mul_a = 34'(mag34(r_v[1])); mul_b = mul_a; end
            M_SQV2: begin mul_a = 34'(mag34(r_v[2])); mul_b = mul_a; end
            M_FF:   begin mul_a = 34'(r_f); mul_b = 34'(r_f); end
            M_MAG:  begin mul_a = 34'(r_strength); mul_b = 34'(r_f2); end
            M_IMP0: begin mul_a = 34'(r_n[0]); mul_b = r_mag; end
            M_IMP1: begin mul_a = 34'(r_n[1]); mul_b = r_mag; end
            M_IMP2: begin mul_a = 34'(r_n[2]); mul_b = r_mag; end
            M_TQ0A: begin mul_a = -34'(r_n[2]); mul_b = r_mag; end
            M_TQ0B: begin mul_a = r_t; mul_b = TENTH_Q; end
            M_TQ1B: begin mul_a = r_imp[0]; mul_b = TENTH_Q; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // floor of the product scaled down by the fraction bits
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign psh     = prod_sh[33:0];

    // one restoring square root step
    always_comb begin
        sq_bit = 64'd1 << {r_cnt, 1'b0};
        sq_t   = r_sq_res + sq_bit;
        sq_ge  = (r_sq_n >= sq_t);
        if (sq_ge) begin
            sq_n_next   = r_sq_n - sq_t;
            sq_res_next = (r_sq_res >> 1) + sq_bit;
        end else begin
            sq_n_next   = r_sq_n;
            sq_res_next = r_sq_res >> 1;
        end
    end
    assign root = sq_res_next[31:0];

    // one restoring division step
    always_comb begin
        dv_diff   = {1'b0, r_dv_rem} - {3'b000, r_dv_den};
        dv_bit    = ~dv_diff[34];
        dv_keep   = dv_bit ? dv_diff[33:0] : r_dv_rem;
        dv_q_next = {r_dv_q[FRAC_BITS-1:0], dv_bit};
        dv_res    = r_dv_neg ? -QW'({1'b0, dv_q_next}) : QW'({1'b0, dv_q_next});
    end

    assign tick_val = {{2{r_time_left[31]}}, r_time_left} - {3'b000, i_in.delta_time};

    always_comb begin
        miss_word         = '0;
        miss_word.expired = (r_time_left <= 0);
    end

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_time_left = r_time_left;
        n_out       = r_out;
        n_pos       = r_pos;
        n_dyn       = r_dyn;
        n_d         = r_d;
        n_v         = r_v;
        n_n         = r_n;
        n_acc       = r_acc;
        n_mop       = r_mop;
        n_sq_n      = r_sq_n;
        n_sq_res    = r_sq_res;
        n_sq_len    = r_sq_len;
        n_cnt       = r_cnt;
        n_dv_rem    = r_dv_rem;
        n_dv_den    = r_dv_den;
        n_dv_q      = r_dv_q;
        n_dv_neg    = r_dv_neg;
        n_dv_kind   = r_dv_kind;
        n_k         = r_k;
        n_dist      = r_dist;
        n_len       = r_len;
        n_f         = r_f;
        n_f2        = r_f2;
        n_mag       = r_mag;
        n_imp       = r_imp;
        n_t         = r_t;
        n_tq0       = r_tq0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_action'(i_in.action))
                        ACT_APPLY: begin
                            n_pos[0] = i_in.pos_x;
                            n_pos[1] = i_in.pos_y;
                            n_pos[2] = i_in.pos_z;
                            n_dyn    = i_in.is_dynamic;
                            n_state  = S_OFFS;
                        end
                        ACT_TICK: begin
                            n_time_left = sat32(tick_val);
                            n_out       = '0;
                            n_out.expired = (sat32(tick_val) <= 0);
                            n_out_valid = 1'b1;
                        end
                        ACT_ARM: begin
                            n_time_left = {1'b0, r_duration};
                            n_out       = '0;
                            n_out.expired = (r_duration == '0);
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out       = miss_word;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            // offset from the centre, liveness check
            S_OFFS: begin
                for (int i = 0; i < 3; i++) begin
                    n_d[i] = 33'(r_pos[i]) - 33'(r_center[i]);
                end
                if (!r_dyn || r_time_left <= 0) begin
                    n_out       = miss_word;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_RANGE;
                end
            end

            // any component beyond the radius is out of reach
            S_RANGE: begin
                if (mag34(34'(r_d[0])) > 34'(r_radius) ||
                    mag34(34'(r_d[1])) > 34'(r_radius) ||
                    mag34(34'(r_d[2])) > 34'(r_radius)) begin
                    n_out       = miss_word;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_acc   = '0;
                    n_mop   = M_SQD0;
                    n_state = S_MUL;
                end
            end

            S_MUL: begin
                n_state = S_MULW;
            end

            // consume the registered product
            S_MULW: begin
                n_state = S_MUL;
                case (r_mop) inside
                    M_SQD0, M_SQD1, M_SQV0, M_SQV1: begin
                        n_acc = r_acc + r_prod[63:0];
                        n_mop = t_mop'(r_mop + 4'd1);
                    end
                    M_SQD2, M_SQV2: begin
                        n_sq_n   = r_acc + r_prod[63:0];
                        n_sq_res = '0;
                        n_sq_len = (r_mop == M_SQV2);
                        n_cnt    = 5'd31;
                        n_state  = S_SQRT;
                    end
                    M_FF: begin
                        n_f2  = psh[QW-1:0];
                        n_mop = M_MAG;
                    end
                    M_MAG: begin
                        n_mag = psh;
                        n_mop = M_IMP0;
                    end
                    M_IMP0: begin
                        n_imp[0] = psh;
                        n_mop    = M_IMP1;
                    end
                    M_IMP1: begin
                        n_imp[1] = psh;
                        n_mop    = M_IMP2;
                    end
                    M_IMP2: begin
                        n_imp[2] = psh;
                        n_mop    = M_TQ0A;
                    end
                    M_TQ0A: begin
                        n_t   = psh;
                        n_mop = M_TQ0B;
                    end
                    M_TQ0B: begin
                        n_tq0 = psh;
                        n_mop = M_TQ1B;
                    end
                    default: begin
                        // last torque product, deliver the hit
                        n_out.applied   = 1'b1;
                        n_out.impulse_x = sat32(r_imp[0]);
                        n_out.impulse_y = sat32(r_imp[1]);
                        n_out.impulse_z = sat32(r_imp[2]);
                        n_out.torque_x  = sat32(r_tq0);
                        n_out.torque_z  = sat32(psh);
                        n_out.expired   = (r_time_left <= 0);
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end
                endcase
            end

            // square root of the accumulated sum, two bits a cycle
            S_SQRT: begin
                n_sq_n   = sq_n_next;
                n_sq_res = sq_res_next;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    if (!r_sq_len) begin
                        n_dist = root;
                        if (root > {1'b0, r_radius}) begin
                            n_out       = miss_word;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end else if (root != '0) begin
                            n_dv_kind = DK_OFFS;
                            n_k       = '0;
                            n_state   = S_DVLD;
                        end else begin
                            // body at the centre points straight up
                            n_v[0]  = '0;
                            n_v[1]  = ONE_Q;
                            n_v[2]  = '0;
                            n_state = S_BIAS;
                        end
                    end else begin
                        n_len = root;
                        if (root == '0) begin
                            for (int i = 0; i < 3; i++) begin
                                n_n[i] = '0;
                            end
                            n_state = S_FALL;
                        end else begin
                            n_dv_kind = DK_VEC;
                            n_k       = '0;
                            n_state   = S_DVLD;
                        end
                    end
                end
            end

            // upward modifier, then squares of the biased direction
            S_BIAS: begin
                n_v[1]  = r_v[1] + 34'(r_bias);
                n_acc   = '0;
                n_mop   = M_SQV0;
                n_state = S_MUL;
            end

            // load the divider
            S_DVLD: begin
                n_dv_q = '0;
                n_cnt  = 5'(FRAC_BITS);
                case (r_dv_kind)
                    DK_OFFS: begin
                        n_dv_rem = mag34(34'(r_d[r_k]));
                        n_dv_neg = r_d[r_k][32];
                        n_dv_den = r_dist;
                    end
                    DK_VEC: begin
                        n_dv_rem = mag34(r_v[r_k]);
                        n_dv_neg = r_v[r_k][33];
                        n_dv_den = r_len;
                    end
                    default: begin
                        n_dv_rem = {2'b00, r_dist};
                        n_dv_neg = 1'b0;
                        n_dv_den = {1'b0, r_radius};
                    end
                endcase
                n_state = S_DIV;
            end

            // one quotient bit a cycle
            S_DIV: begin
                n_dv_rem = {dv_keep[32:0], 1'b0};
                n_dv_q   = dv_q_next;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    case (r_dv_kind)
                        DK_OFFS: begin
                            n_v[r_k] = 34'(dv_res);
                            n_k      = r_k + 2'd1;
                            n_state  = (r_k == 2'd2) ? S_BIAS : S_DVLD;
                        end
                        DK_VEC: begin
                            n_n[r_k] = dv_res;
                            n_k      = r_k + 2'd1;
                            n_state  = (r_k == 2'd2) ? S_FALL : S_DVLD;
                        end
                        default: begin
                            n_f     = QW'(ONE_Q) - dv_res;
                            n_mop   = M_FF;
                            n_state = S_MUL;
                        end
                    endcase
                end
            end

            // falloff 1 - d/r, full strength for a zero radius
            S_FALL: begin
                if (r_radius == '0) begin
                    n_f     = QW'(ONE_Q);
                    n_mop   = M_FF;
                    n_state = S_MUL;
                end else begin
                    n_dv_kind = DK_FALL;
                    n_state   = S_DVLD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_time_left <= 32'sd32768;
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= 31'd65536;
            r_strength  <= '0;
            r_bias      <= 32'sd6554;
            r_duration  <= 31'd32768;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_time_left <= n_time_left;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTER_X: r_center[0] <= i_cfg_data;
                    CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                    CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                    CFG_RADIUS:   r_radius    <= i_cfg_data[30:0];
                    CFG_STRENGTH: r_strength  <= i_cfg_data;
                    CFG_BIAS:     r_bias      <= i_cfg_data;
                    CFG_DURATION: r_duration  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_pos     <= n_pos;
        r_dyn     <= n_dyn;
        r_d       <= n_d;
        r_v       <= n_v;
        r_n       <= n_n;
        r_acc     <= n_acc;
        r_prod    <= mul_a * mul_b;
        r_mop     <= n_mop;
        r_sq_n    <= n_sq_n;
        r_sq_res  <= n_sq_res;
        r_sq_len  <= n_sq_len;
        r_cnt     <= n_cnt;
        r_dv_rem  <= n_dv_rem;
        r_dv_den  <= n_dv_den;
        r_dv_q    <= n_dv_q;
        r_dv_neg  <= n_dv_neg;
        r_dv_kind <= n_dv_kind;
        r_k       <= n_k;
        r_dist    <= n_dist;
        r_len     <= n_len;
        r_f       <= n_f;
        r_f2      <= n_f2;
        r_mag     <= n_mag;
        r_imp     <= n_imp;
        r_t       <= n_t;
        r_tq0     <= n_tq0;
    end

    // a strobe never shows while the sequencer is working
    `EIU_ASSERT_NOW(a_no_strobe_busy, busy, !o_out_valid)
    // an accepted apply always occupies the sequencer next cycle
    `EIU_ASSERT_NEXT(a_apply_busy, start && !busy && i_in.action == ACT_APPLY, busy)
    // a result without impulse carries all zero vectors
    `EIU_ASSERT_NOW(a_miss_zero, o_out_valid && !o_out.applied, o_out.impulse_x == 0 && o_out.impulse_y == 0 && o_out.impulse_z == 0 && o_out.torque_x == 0 && o_out.torque_z == 0)

endmodule

// ----- bench/explosion_impulse_unit_tb.sv -----
`timescale 1ns / 1ps

module explosion_impulse_unit_tb;
    import eiu_pkg::*;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam longint     ONE_Q      = 64'sd1 << FRAC_BITS;
    localparam longint     TENTH_Q    = (ONE_Q + 5) / 10;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         DRAIN_WAIT  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        start = 1'b0;
    t_in_word    i_in = '0;
    logic        busy;
    logic        o_out_valid;
    t_out_word   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    explosion_impulse_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in        (i_in),
        .busy        (busy),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // blast settings and remaining lifetime as the block should hold them
    longint          blast_cx, blast_cy, blast_cz, blast_force, lift_bias;
    longint unsigned blast_reach, blast_life;
    longint          life_left = 32768;

    t_in_word  cmd_queue[$];
    t_out_word expected_words[$];
    int        mismatches = 0;
    int        words_checked = 0;
    int        impulse_hits = 0;
    int        settings_used;
    int        cycle_count = 0;
    int        gap_left = 0;
    bit        gaps_enabled;
    bit        cmd_taken = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // fixed-point divide, truncated toward zero
    function automatic longint fx_div(longint v, longint unsigned den);
        longint unsigned q;
        q = (abs64(v) << FRAC_BITS) / den;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    // fixed-point multiply, floor
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // impulse of one apply command, returns 0 on a miss
    function automatic bit blast_impulse(t_in_word w, output longint imp[3],
                                         output longint tqx, output longint tqz);
        longint          off[3], dir[3], unit[3];
        longint unsigned sum, span, len;
        longint          fall, fall2, mag;
        imp = '{0, 0, 0};
        tqx = 0;
        tqz = 0;
        if (!w.is_dynamic || life_left <= 0) return 0;
        off[0] = longint'(w.pos_x) - blast_cx;
        off[1] = longint'(w.pos_y) - blast_cy;
        off[2] = longint'(w.pos_z) - blast_cz;
        for (int i = 0; i < 3; i++) if (abs64(off[i]) > blast_reach) return 0;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += abs64(off[i]) * abs64(off[i]);
        span = int_sqrt(sum);
        if (span > blast_reach) return 0;
        if (span > 0) begin
            for (int i = 0; i < 3; i++) dir[i] = fx_div(off[i], span);
        end else begin
            dir = '{0, ONE_Q, 0};
        end
        dir[1] += lift_bias;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += abs64(dir[i]) * abs64(dir[i]);
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) unit[i] = (len == 0) ? 0 : fx_div(dir[i], len);
        fall = (blast_reach == 0) ? ONE_Q : ONE_Q - fx_div(longint'(span), blast_reach);
        fall2 = fx_mul(fall, fall);
        mag = fx_mul(blast_force, fall2);
        for (int i = 0; i < 3; i++) imp[i] = clamp32(fx_mul(unit[i], mag));
        tqx = clamp32(fx_mul(fx_mul(-unit[2], mag), TENTH_Q));
        tqz = clamp32(fx_mul(fx_mul(unit[0], mag), TENTH_Q));
        return 1;
    endfunction

    // expected result word of one command, advances the lifetime
    function automatic t_out_word predict_word(t_in_word w);
        t_out_word r;
        longint    imp[3];
        longint    tqx, tqz;
        bit        hit;
        hit = 0;
        imp = '{0, 0, 0};
        tqx = 0;
        tqz = 0;
        case (w.action)
            ACT_APPLY: begin
                hit = blast_impulse(w, imp, tqx, tqz);
                if (hit) impulse_hits++;
            end
            ACT_TICK: life_left = clamp32(life_left - longint'(w.delta_time));
            ACT_ARM:  life_left = longint'(blast_life);
            default: ;
        endcase
        r.applied   = hit;
        r.impulse_x = imp[0][31:0];
        r.impulse_y = imp[1][31:0];
        r.impulse_z = imp[2][31:0];
        r.torque_x  = tqx[31:0];
        r.torque_z  = tqz[31:0];
        r.expired   = (life_left <= 0);
        return r;
    endfunction

    // append one command to the pending list
    function automatic void queue_cmd(t_in_word w);
        cmd_queue.insert(cmd_queue.size(), w);
    endfunction

    // accept commands and check result words
    always @(posedge i_clk) begin
        t_out_word want;
        cmd_taken = i_rst_n && start && !busy;
        if (cmd_taken) expected_words.insert(expected_words.size(), predict_word(i_in));
        if (i_rst_n && o_out_valid) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_out);
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (o_out.applied !== want.applied || o_out.impulse_x !== want.impulse_x ||
                    o_out.impulse_y !== want.impulse_y || o_out.impulse_z !== want.impulse_z ||
                    o_out.torque_x !== want.torque_x || o_out.torque_z !== want.torque_z ||
                    o_out.expired !== want.expired) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d mismatch: expected ap=%0d imp=(%0d %0d %0d) tq=(%0d %0d) ex=%0d",
                                 words_checked, want.applied, want.impulse_x, want.impulse_y,
                                 want.impulse_z, want.torque_x, want.torque_z, want.expired);
                        $display("    actual: ap=%0d imp=(%0d %0d %0d) tq=(%0d %0d) ex=%0d",
                                 o_out.applied, o_out.impulse_x, o_out.impulse_y,
                                 o_out.impulse_z, o_out.torque_x, o_out.torque_z, o_out.expired);
                    end
                end
            end
        end
    end

    // command driver with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || cmd_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                start <= 1'b0;
            end else if (gaps_enabled && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 17);
                start <= 1'b0;
            end else begin
                i_in  <= cmd_queue.pop_front();
                start <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("explosion_impulse_unit_tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER_X: blast_cx = longint'(signed'(data));
            CFG_CENTER_Y: blast_cy = longint'(signed'(data));
            CFG_CENTER_Z: blast_cz = longint'(signed'(data));
            CFG_RADIUS:   blast_reach = data[30:0];
            CFG_STRENGTH: blast_force = longint'(signed'(data));
            CFG_BIAS:     lift_bias = longint'(signed'(data));
            CFG_DURATION: blast_life = data[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, logic [31:0] str, logic [31:0] bias,
                             logic [31:0] dur);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_STRENGTH, str);
        write_reg(CFG_BIAS, bias);
        write_reg(CFG_DURATION, dur);
        settings_used++;
    endtask

    function automatic t_in_word make_cmd(logic [1:0] act, longint px, longint py,
                                          longint pz, bit dyn, logic [30:0] dt);
        t_in_word w;
        w.action     = act;
        w.pos_x      = 32'(clamp32(px));
        w.pos_y      = 32'(clamp32(py));
        w.pos_z      = 32'(clamp32(pz));
        w.is_dynamic = dyn;
        w.delta_time = dt;
        return w;
    endfunction

    // offset that mostly lands inside the blast sphere
    function automatic longint near_offset();
        longint o;
        o = longint'($urandom % (blast_reach / 2 + 1));
        if ($urandom_range(0, 1)) o = -o;
        return o;
    endfunction

    function automatic t_in_word rand_cmd();
        int      pick;
        longint  ox, oy, oz;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            ox = near_offset();
            oy = near_offset();
            oz = near_offset();
            if (pick < 4) begin
                ox = 0; oy = 0; oz = 0;
            end
            return make_cmd(ACT_APPLY, blast_cx + ox, blast_cy + oy, blast_cz + oz,
                            $urandom_range(0, 9) != 0, 31'($urandom));
        end else if (pick < 68) begin
            return make_cmd(ACT_APPLY, signed'($urandom), signed'($urandom),
                            signed'($urandom), 1'($urandom_range(0, 1)), 31'($urandom));
        end else if (pick < 82) begin
            return make_cmd(ACT_TICK, signed'($urandom), signed'($urandom), signed'($urandom),
                            1'($urandom_range(0, 1)),
                            $urandom_range(0, 19) == 0 ? 31'($urandom)
                                                       : 31'($urandom % (blast_life / 8 + 1)));
        end else if (pick < 95) begin
            return make_cmd(ACT_ARM, signed'($urandom), signed'($urandom), signed'($urandom),
                            1'($urandom_range(0, 1)), 31'($urandom));
        end
        return make_cmd(ACT_NONE, signed'($urandom), signed'($urandom), signed'($urandom),
                        1'($urandom_range(0, 1)), 31'($urandom));
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || busy || expected_words.size() != 0);
    endtask

    initial begin
        longint r;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        settings_used = 1;
        gaps_enabled = 1'b1;
        blast_cx = 0; blast_cy = 0; blast_cz = 0;
        blast_reach = 65536; blast_force = 0; lift_bias = 6554;
        blast_life = 32768;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero strength, live blast
        queue_cmd(make_cmd(ACT_APPLY, 0, 0, 0, 1, 0));
        queue_cmd(make_cmd(ACT_APPLY, 1000, -2000, 3000, 1, 0));
        wait_idle();

        // directed checks around a 4.0 radius blast
        write_all(0, 0, 0, 32'h0004_0000, 32'h0008_0000, 6554, 32'h0002_0000);
        r = 64'sh40000;
        queue_cmd(make_cmd(ACT_APPLY, 0, 0, 0, 1, 0));            // at centre
        queue_cmd(make_cmd(ACT_APPLY, 100, 200, 300, 0, 0));      // static body
        queue_cmd(make_cmd(ACT_APPLY, r + 1, 0, 0, 1, 0));        // far component
        queue_cmd(make_cmd(ACT_APPLY, r, 0, 0, 1, 0));            // on the edge
        queue_cmd(make_cmd(ACT_APPLY, 0, 0, -r, 1, 0));
        queue_cmd(make_cmd(ACT_APPLY, r - 5, r - 5, 0, 1, 0));    // components in reach, distance outside
        queue_cmd(make_cmd(ACT_APPLY, r / 2, -r / 3, r / 4, 1, 0));
        queue_cmd(make_cmd(ACT_APPLY, 64'sh7FFFFFFF, 64'sh7FFFFFFF,
                           64'sh7FFFFFFF, 1, 31'h7FFFFFFF));
        queue_cmd(make_cmd(ACT_APPLY, -64'sh80000000, -64'sh80000000,
                           -64'sh80000000, 1, 0));
        queue_cmd(make_cmd(ACT_NONE, 1, 1, 1, 1, 5));
        queue_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 31'h0001_0000));
        queue_cmd(make_cmd(ACT_APPLY, 1, 2, 3, 1, 0));
        queue_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 31'h0001_0000));  // still expired
        queue_cmd(make_cmd(ACT_APPLY, 1, 2, 3, 1, 0));
        queue_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 31'h7FFFFFFF));
        queue_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 31'h7FFFFFFF));  // saturates
        queue_cmd(make_cmd(ACT_ARM, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(ACT_APPLY, -r / 5, r / 7, 9, 1, 0));
        wait_idle();

        // zero radius with a bias that cancels the up direction
        write_all(32'h0010_0000, 32'hFFF0_0000, 32'h1234_5678, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        queue_cmd(make_cmd(ACT_ARM, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(ACT_APPLY, blast_cx, blast_cy, blast_cz, 1, 0));
        queue_cmd(make_cmd(ACT_APPLY, blast_cx + 1, blast_cy, blast_cz, 1, 0));
        queue_cmd(make_cmd(ACT_APPLY, blast_cx, blast_cy, blast_cz, 0, 0));
        wait_idle();

        // random phases, extremes first
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
                2: write_all($urandom, $urandom, $urandom, $urandom_range(1, 255),
                             $urandom, $urandom_range(0, 32'h0002_0000), $urandom);
                default: write_all($urandom, $urandom, $urandom,
                                   $urandom_range(32'h0000_0400, 32'h0100_0000),
                                   signed'($urandom) >>> $urandom_range(0, 12),
                                   signed'($urandom) >>> $urandom_range(12, 20),
                                   $urandom_range(32'h0000_4000, 32'h0800_0000));
            endcase
            if (p == 6) gaps_enabled = 1'b0;
            queue_cmd(make_cmd(ACT_ARM, 0, 0, 0, 0, 0));
            for (int k = 0; k < 132; k++) queue_cmd(rand_cmd());
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("checked %0d result words, %0d impulse hits, over %0d blast settings",
                 words_checked, impulse_hits, settings_used);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("explosion_impulse_unit_tb passed");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
            $display("explosion_impulse_unit_tb failed");
        end
        $finish;
    end

endmodule
